[design/svar_pkg.sv]
// ============================================================================
// svar_pkg
// Shared sizes, request types and register codes for the sample variance block.
// ============================================================================
`default_nettype none

package svar_pkg;

    // Store depth and column range.
    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_COLUMNS = 1024;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 24;
    localparam int COL_W    = 10;
    localparam int VAR_W    = 62;

    // Widths that follow from the sample width and the store depth.
    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_W + ADDR_W + 1;
    localparam int MEAN_W  = SAMPLE_W + 1;
    localparam int ABS_W   = SAMPLE_W;
    localparam int PROD_W  = 2 * ABS_W;
    localparam int SQ_W    = PROD_W + ADDR_W;
    localparam int DIV_W   = SQ_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_COLUMN_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_COLUMN = 1'd1;

    // One input request.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]           column_index;
        logic                       last;
    } t_in;

    // One result.
    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic [CNT_W-1:0] kept_count;
        logic             too_few;
        logic             overflowed;
    } t_out;

endpackage

`default_nettype wire

[design/sample_variance.sv]
// ============================================================================
// sample_variance
// Two-pass unbiased sample variance over a stream of matrix elements held in
// an on-chip sample store.
// ============================================================================
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  request  | in        | start, busy               | i_item   (t_in)
//  result   | out       | o_result_valid (strobe)   | o_result (t_out)
//  config   | in        | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  A request without last leaves busy low, and the next request can follow
//  at once. A request with last holds busy until its result (DIV_W = 60):
//  the bit-serial divider produces one quotient bit a cycle for the mean and
//  for the final quotient, and the second pass reads the store through its
//  single read port, one sample a cycle. With fewer than two kept samples
//  the result is set from S_START, without the divider or the second pass.
//  The result strobe lasts one cycle and cannot be stalled.
//  Reset is synchronous; the sample store needs no clearing after reset.
// ============================================================================
`default_nettype none

module sample_variance
    import svar_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in                  i_item,
    output logic                      o_result_valid,
    output t_out                      o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COL_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MEAN,
        S_PASS,
        S_VAR
    } t_state;

    t_state                    r_state;
    logic                      r_one_col;
    logic [COL_W-1:0]          r_sel_col;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_count;
    logic                      r_dropped;
    logic signed [MEAN_W-1:0]  r_mean;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic [ABS_W-1:0]          r_abs;
    logic [PROD_W-1:0]         r_prod;
    logic [SQ_W-1:0]           r_sq;
    logic                      r_out_valid;
    t_out                      r_out;

    logic                      accept;
    logic                      keep;
    logic                      room;
    logic                      store_we;
    logic                      issue;
    logic                      drained;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_W-1:0]          div_dividend;
    logic [CNT_W-1:0]          div_divisor;
    logic [DIV_W-1:0]          div_quotient;
    logic [SUM_W-1:0]          sum_mag;
    logic signed [MEAN_W-1:0]  q_mean;
    logic [SAMPLE_W-1:0]       rd_sample;
    logic signed [MEAN_W:0]    dev;
    logic [MEAN_W:0]           dev_mag;

    // Request acceptance and the keep decision for the arriving sample.
    always_comb begin
        accept   = start && !busy;
        keep     = r_one_col
                   ? (i_item.column_index == r_sel_col
                      && 32'(i_item.column_index) < MAX_COLUMNS)
                   : 1'b1;
        room     = r_count < CNT_W'(MAX_SAMPLES);
        store_we = accept && keep && room;
    end

    // Second-pass read issue and pipeline drain.
    always_comb begin
        issue   = (r_state == S_PASS) && (r_idx != r_count);
        drained = (r_state == S_PASS) && (r_idx == r_count) && !r_v1 && !r_v2 && !r_v3;
    end

    // Shared divider: magnitude of the sum for the mean, squared sum at the end.
    always_comb begin
        sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        if (r_state == S_START) begin
            div_dividend = DIV_W'(sum_mag);
            div_divisor  = r_count;
        end else begin
            div_dividend = DIV_W'(r_sq);
            div_divisor  = r_count - 1'b1;
        end
        div_start = ((r_state == S_START) && r_count >= CNT_W'(2)) || drained;
        q_mean    = r_sum[SUM_W-1] ? -$signed(div_quotient[MEAN_W-1:0])
                                   : $signed(div_quotient[MEAN_W-1:0]);
    end

    // Deviation of a stored sample from the mean.
    always_comb begin
        dev     = $signed({rd_sample[SAMPLE_W-1], rd_sample[SAMPLE_W-1], rd_sample})
                  - $signed({r_mean[MEAN_W-1], r_mean});
        dev_mag = dev[MEAN_W] ? (MEAN_W + 1)'(-dev) : (MEAN_W + 1)'(dev);
    end

    // Sample store.
    svar_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_item.sample),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_sample)
    );

    // Divider.
    svar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Second-pass datapath: deviation magnitude and square; the accumulation is in the control block.
    always_ff @(posedge i_clk) begin
        r_abs  <= dev_mag[ABS_W-1:0];
        r_prod <= r_abs * r_abs;
    end

    // Control, configuration registers, accumulators and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_one_col   <= 1'b0;
            r_sel_col   <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_idx       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_sq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_v1        <= issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;

            // Configuration writes.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ONE_COLUMN_MODE: r_one_col <= i_cfg_data[0];
                    CFG_SELECTED_COLUMN: r_sel_col <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (keep && room) begin
                            r_sum   <= r_sum + SUM_W'(i_item.sample);
                            r_count <= r_count + 1'b1;
                        end else if (keep) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_idx <= '0;
                    r_sq  <= '0;
                    if (r_count < CNT_W'(2)) begin
                        r_out.variance   <= '0;
                        r_out.kept_count <= r_count;
                        r_out.too_few    <= 1'b1;
                        r_out.overflowed <= r_dropped;
                        r_out_valid      <= 1'b1;
                        r_sum            <= '0;
                        r_count          <= '0;
                        r_dropped        <= 1'b0;
                        r_state          <= S_IDLE;
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean  <= q_mean;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    if (issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_v3) begin
                        r_sq <= r_sq + SQ_W'(r_prod);
                    end
                    if (drained) begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (div_done) begin
                        r_out.variance   <= VAR_W'(div_quotient);
                        r_out.kept_count <= r_count;
                        r_out.too_few    <= 1'b0;
                        r_out.overflowed <= r_dropped;
                        r_out_valid      <= 1'b1;
                        r_sum            <= '0;
                        r_count          <= '0;
                        r_dropped        <= 1'b0;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef ASSERT_OFF
    // The kept count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("kept count beyond store depth");

    // The accumulators are already cleared while a result is shown.
    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count == '0 && !r_dropped && r_state == S_IDLE))
        else $error("accumulators not cleared with the result");

    // A too-few result always carries a zero variance.
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.too_few |-> r_out.variance == '0)
        else $error("too-few result with nonzero variance");

    // The read index never runs past the kept count during the second pass.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PASS |-> r_idx <= r_count)
        else $error("second-pass index beyond kept count");

    // Results are single-cycle strobes.
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

`default_nettype wire

[design/svar_ram.sv]
// ============================================================================
// svar_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module svar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/svar_div.sv]
// ============================================================================
// svar_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the mean
// and the final variance division.
// ============================================================================
`default_nettype none

module svar_div
    import svar_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [DIV_W-1:0]  r_quo;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W:0]    diff;

    // Trial subtraction of the next dividend bit.
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        fits  = trial >= {1'b0, r_dsr};
        diff  = trial - {1'b0, r_dsr};
    end

    // Control: step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and shifting dividend/quotient word.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef ASSERT_OFF
    // The remainder always stays below the divisor while dividing.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_dsr != '0 |=> r_rem < r_dsr)
        else $error("divider remainder not below divisor");

    // A done pulse only ends a running division.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    // Done is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");
`endif

endmodule

`default_nettype wire
